>>> design/dcl_pkg.sv
// Shared constants and codes for the doubly linked circular list engine.
package dcl_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int VAL_W        = 32;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 2;
    localparam int OCNT_W       = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD  = 3'd0,
        OP_INS_TAIL  = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_DELETE    = 3'd3,
        OP_SEARCH    = 3'd4,
        OP_DUMP_FWD  = 3'd5,
        OP_DUMP_BACK = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

endpackage

>>> design/dcl_ram.sv
// Generic single-write, single-read memory with registered read data.
module dcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/doubly_circular_list_engine_top.sv
// Top level of the doubly linked circular list engine.
//
// A doubly linked circular list of signed 32-bit values lives in three memories
// (value, next link, previous link) with registered reads; slot occupancy is
// kept in flip-flops and a new node takes the lowest free slot.
// One request is handled at a time. An insert at head or tail passes S_PRE,
// S_LINK1 and S_LINK2 before S_EMIT (only S_LINK1 into an empty list, and
// straight to S_EMIT when the pool is full). Searches walk in S_WALK; deletes
// then pass S_UNLINK and inserts-after S_LINK1 and S_LINK2. The walk feeds each
// read's next link straight back into the read address. A dump gives one word
// per cycle while the output is not stalled. A new request is taken while the
// last word of the previous one still waits at the output.
module doubly_circular_list_engine_top #(
    parameter int CAPACITY = dcl_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0], key[34:3], value[66:35], zero fill above
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // count[5:0], item_value[37:6], zero fill above
    output logic [39:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = dcl_pkg::VAL_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PRE    = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_LINK1  = 8'b0000_1000,
        S_LINK2  = 8'b0001_0000,
        S_UNLINK = 8'b0010_0000,
        S_DUMP   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    dcl_pkg::t_op     in_op;
    logic [VW-1:0]    in_key, in_value;

    logic [CAPACITY-1:0] r_used, n_used;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    dcl_pkg::t_op    r_op, n_op;
    logic [VW-1:0]   r_key, n_key;
    logic [VW-1:0]   r_val, n_val;
    logic [AW-1:0]   r_cur, n_cur;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_total, n_total;
    logic [AW-1:0]   r_s, n_s;
    logic [AW-1:0]   r_a, n_a;
    logic [AW-1:0]   r_b, n_b;
    logic            r_empty, n_empty;
    dcl_pkg::t_status r_stat, n_stat;

    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_ostat, n_ostat;
    logic [dcl_pkg::OCNT_W-1:0] r_ocnt, n_ocnt;
    logic [VW-1:0]   r_oval, n_oval;
    logic            r_olast, n_olast;

    logic [AW-1:0]   free_slot;
    logic            out_free, accept;
    logic [AW-1:0]   raddr;
    logic [VW-1:0]   rd_val;
    logic [AW-1:0]   rd_next, rd_prev;

    logic            val_we, next_we, prev_we;
    logic [AW-1:0]   val_wa, next_wa, prev_wa;
    logic [AW-1:0]   next_wd, prev_wd;
    logic            n_last_walk;

    assign in_op    = dcl_pkg::t_op'(s_axis_tdata[2:0]);
    assign in_key   = s_axis_tdata[34:3];
    assign in_value = s_axis_tdata[66:35];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = AW'(i);
            end
        end
    end

    dcl_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(r_val),
        .i_raddr(raddr), .o_rdata(rd_val)
    );
    dcl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(raddr), .o_rdata(rd_next)
    );
    dcl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(raddr), .o_rdata(rd_prev)
    );

    assign n_last_walk = (CW'(r_n + 1'b1) == r_count);

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_head   = r_head;
        n_count  = r_count;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_cur    = r_cur;
        n_n      = r_n;
        n_total  = r_total;
        n_s      = r_s;
        n_a      = r_a;
        n_b      = r_b;
        n_empty  = r_empty;
        n_stat   = r_stat;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ostat  = r_ostat;
        n_ocnt   = r_ocnt;
        n_oval   = r_oval;
        n_olast  = r_olast;
        raddr    = r_cur;
        val_we   = 1'b0;
        next_we  = 1'b0;
        prev_we  = 1'b0;
        val_wa   = r_s;
        next_wa  = r_s;
        prev_wa  = r_s;
        next_wd  = r_b;
        prev_wd  = r_a;

        case (r_state)
            S_IDLE: begin
                raddr = r_head;
                if (accept) begin
                    n_op    = in_op;
                    n_val   = in_value;
                    n_key   = (in_op == dcl_pkg::OP_DELETE) ? in_value : in_key;
                    n_cur   = r_head;
                    n_n     = '0;
                    n_s     = free_slot;
                    n_empty = (r_count == '0);
                    n_total = (int'(r_count) < dcl_pkg::MAX_RESULTS) ? r_count
                              : CW'(dcl_pkg::MAX_RESULTS);
                    n_stat  = dcl_pkg::ST_OK;
                    n_state = S_EMIT;
                    case (in_op)
                        dcl_pkg::OP_INS_HEAD, dcl_pkg::OP_INS_TAIL: begin
                            if (int'(r_count) >= CAPACITY) begin
                                n_stat = dcl_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_a     = free_slot;
                                n_b     = free_slot;
                                n_state = S_LINK1;
                            end else begin
                                n_state = S_PRE;
                            end
                        end
                        dcl_pkg::OP_INS_AFTER: begin
                            if (r_count == '0) begin
                                n_stat = dcl_pkg::ST_EMPTY;
                            end else if (int'(r_count) >= CAPACITY) begin
                                n_stat = dcl_pkg::ST_FULL;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        dcl_pkg::OP_DELETE, dcl_pkg::OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_stat = dcl_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        dcl_pkg::OP_DUMP_FWD, dcl_pkg::OP_DUMP_BACK: begin
                            if (r_count == '0) begin
                                n_stat = dcl_pkg::ST_EMPTY;
                            end else if (in_op == dcl_pkg::OP_DUMP_FWD) begin
                                n_state = S_DUMP;
                            end else begin
                                n_state = S_PRE;
                            end
                        end
                        default: begin
                            n_stat = dcl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_PRE: begin
                // Read data holds the head node; its previous link is the tail.
                if (r_op == dcl_pkg::OP_DUMP_BACK) begin
                    n_cur   = rd_prev;
                    raddr   = rd_prev;
                    n_state = S_DUMP;
                end else begin
                    n_a     = rd_prev;
                    n_b     = r_head;
                    n_state = S_LINK1;
                end
            end
            S_WALK: begin
                if (rd_val == r_key) begin
                    n_stat = dcl_pkg::ST_OK;
                    case (r_op)
                        dcl_pkg::OP_INS_AFTER: begin
                            n_a     = r_cur;
                            n_b     = rd_next;
                            n_state = S_LINK1;
                        end
                        dcl_pkg::OP_DELETE: begin
                            n_a     = rd_prev;
                            n_b     = rd_next;
                            n_state = S_UNLINK;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end else if (n_last_walk) begin
                    n_stat  = dcl_pkg::ST_NOT_FOUND;
                    n_state = S_EMIT;
                end else begin
                    n_cur = rd_next;
                    raddr = rd_next;
                    n_n   = CW'(r_n + 1'b1);
                end
            end
            S_LINK1: begin
                val_we    = 1'b1;
                next_we   = 1'b1;
                prev_we   = 1'b1;
                n_used[r_s] = 1'b1;
                n_count = CW'(r_count + 1'b1);
                if (r_empty) begin
                    next_wd = r_s;
                    prev_wd = r_s;
                    n_head  = r_s;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LINK2;
                end
            end
            S_LINK2: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                next_wa = r_a;
                next_wd = r_s;
                prev_wa = r_b;
                prev_wd = r_s;
                if (r_op == dcl_pkg::OP_INS_HEAD) begin
                    n_head = r_s;
                end
                n_state = S_EMIT;
            end
            S_UNLINK: begin
                // r_a and r_b hold the neighbors of the node at r_cur.
                if (r_count <= CW'(1)) begin
                    n_head = '0;
                end else begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                    next_wa = r_a;
                    next_wd = r_b;
                    prev_wa = r_b;
                    prev_wd = r_a;
                    if (r_cur == r_head) begin
                        n_head = r_b;
                    end
                end
                n_used[r_cur] = 1'b0;
                n_count = CW'(r_count - 1'b1);
                n_state = S_EMIT;
            end
            S_DUMP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = dcl_pkg::ST_OK;
                    n_ocnt   = dcl_pkg::OCNT_W'(r_count);
                    n_oval   = rd_val;
                    n_olast  = (CW'(r_n + 1'b1) == r_total);
                    n_n      = CW'(r_n + 1'b1);
                    n_cur    = (r_op == dcl_pkg::OP_DUMP_FWD) ? rd_next : rd_prev;
                    raddr    = n_cur;
                    if (CW'(r_n + 1'b1) == r_total) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_stat;
                    n_ocnt   = dcl_pkg::OCNT_W'(r_count);
                    n_oval   = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_val   <= n_val;
        r_cur   <= n_cur;
        r_n     <= n_n;
        r_total <= n_total;
        r_s     <= n_s;
        r_a     <= n_a;
        r_b     <= n_b;
        r_empty <= n_empty;
        r_stat  <= n_stat;
        r_ostat <= n_ostat;
        r_ocnt  <= n_ocnt;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oval, r_ocnt};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

    // The occupancy bits and the node count must always agree.
    a_used_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_count))
        else $error("slot occupancy disagrees with node count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= CAPACITY)
        else $error("node count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == CW'($past(r_count) + 1'b1) ||
             r_count == CW'($past(r_count) - 1'b1)))
        else $error("node count moved by more than one");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in progress");

endmodule
